[src/mtw_pkg.sv]
// Shared types, constants and word functions of the MT19937 word generator.
`default_nettype none

package mtw_pkg;

	localparam int unsigned POOL_WORDS = 624;
	localparam int unsigned TAP_OFFSET = 397;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned CNT_W      = $clog2(POOL_WORDS);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  fill_cnt_t;

	localparam word_t SEED_RESET      = 32'd5489;
	localparam word_t INIT_MULT       = 32'd1812433253;
	localparam word_t FEEDBACK_MATRIX = 32'h9908_b0df;
	localparam word_t TOP_BIT         = 32'h8000_0000;
	localparam word_t LOW_BITS        = 32'h7fff_ffff;
	localparam word_t TEMPER_B        = 32'h9d2c_5680;
	localparam word_t TEMPER_C        = 32'hefc6_0000;

	localparam fill_cnt_t FILL_LAST = fill_cnt_t'(POOL_WORDS - 1);

	// Control from the seeding unit to the cell chain.
	typedef struct packed {
		logic busy;
		logic last;
	} fill_ctrl_t;

	// One step of the seeding recurrence.
	function automatic word_t init_next(input word_t prev, input fill_cnt_t idx);
		word_t mixed;
		begin
			mixed = prev ^ (prev >> 30);
			return word_t'(INIT_MULT * mixed) + word_t'(idx);
		end
	endfunction

	// New value of one pool word from the word itself, its successor and the tap.
	function automatic word_t twist_word(input word_t cur, input word_t nxt,
			input word_t tap);
		word_t y;
		word_t fb;
		begin
			y  = (cur & TOP_BIT) | (nxt & LOW_BITS);
			fb = y[0] ? FEEDBACK_MATRIX : '0;
			return tap ^ (y >> 1) ^ fb;
		end
	endfunction

	function automatic word_t temper(input word_t w);
		word_t y;
		begin
			y = w;
			y = y ^ (y >> 11);
			y = y ^ ((y << 7) & TEMPER_B);
			y = y ^ ((y << 15) & TEMPER_C);
			y = y ^ (y >> 18);
			return y;
		end
	endfunction

endpackage

`default_nettype wire

[src/mt19937_word_generator_top.sv]
// Top level of the MT19937 word generator: cell chain, seeding unit and output stage.
// The tempered word of an accepted request shows in the output register in the next cycle.
// Throughput: one item per cycle when not stalled; the chain twists one pool word per draw.
// Reset and each seed write start a fill of all 624 words, one word per cycle through the
// seeding multiplier, during which req_stall is high; the chain then holds the seeded pool.
// Reset clears the control state and the pending output; the seed returns to 5489.
`default_nettype none

module mt19937_word_generator_top (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               seed_we,
	input  wire [31:0]        seed_value,
	input  wire               req_valid,
	output logic              req_stall,
	input  wire               request,
	output logic              word_valid,
	input  wire               word_stall,
	output logic [31:0]       random_word
);

	// The pool lives in a circular chain of cells. Cell 0 holds the next word to
	// be drawn; cell 1 its successor and cell TAP_OFFSET the feedback tap. A draw
	// twists the head word, shifts the chain by one and feeds the new word in at
	// the tail, so that later draws see it exactly as an in-place twist would.

	mtw_pkg::word_t     cell_q [mtw_pkg::POOL_WORDS];
	mtw_pkg::word_t     cell_d [mtw_pkg::POOL_WORDS];
	mtw_pkg::word_t     tail_d;
	mtw_pkg::word_t     fill_word;
	mtw_pkg::word_t     twisted;
	mtw_pkg::word_t     tempered;
	mtw_pkg::fill_ctrl_t fill;
	logic               accept;
	logic               draw;
	logic               shift_en;
	logic               word_valid_q;
	mtw_pkg::word_t     word_q;

	mtw_seeder u_seeder (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_value (seed_value),
		.ctrl       (fill),
		.fill_word  (fill_word)
	);

	mtw_twist u_twist (
		.head     (cell_q[0]),
		.next     (cell_q[1]),
		.tap      (cell_q[mtw_pkg::TAP_OFFSET]),
		.twisted  (twisted),
		.tempered (tempered)
	);

	// During a fill the seeding unit feeds the tail; otherwise the twisted word.
	assign tail_d   = fill.busy ? fill_word : twisted;
	assign shift_en = fill.busy | draw;

	for (genvar k = 0; k < mtw_pkg::POOL_WORDS; k++) begin : g_cell
		if (k < mtw_pkg::POOL_WORDS - 1) begin : g_mid
			assign cell_d[k] = cell_q[k + 1];
		end else begin : g_tail
			assign cell_d[k] = tail_d;
		end

		mtw_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d[k]),
			.q        (cell_q[k])
		);
	end

	// The output register is refilled in the same cycle it is emptied, so a
	// waiting word only stalls the input while the downstream side stalls too.
	assign req_stall = fill.busy | (word_valid_q & word_stall);
	assign accept    = req_valid & ~req_stall;
	// An item with request low is taken and produces nothing.
	assign draw      = accept & request;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else if (draw) begin
			word_valid_q <= 1'b1;
		end else if (!word_stall) begin
			word_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw) begin
			word_q <= tempered;
		end
	end

	assign word_valid  = word_valid_q;
	assign random_word = word_q;

`ifndef SYNTHESIS
	// A fill ends only after its last word has been shifted into the chain.
	a_fill_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(fill.busy) |-> $past(fill.last))
		else $error("fill ended before the whole pool was seeded");

	// A new output item comes only from an accepted request.
	a_word_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(word_valid) |-> $past(req_valid && !req_stall && request))
		else $error("output item without an accepted request");

	// Every accepted request yields an output item in the next cycle.
	a_request_yields_word: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && request) |=> word_valid)
		else $error("accepted request produced no output item");
`endif

endmodule

`default_nettype wire

[src/mtw_cell.sv]
// One pool word of the circular shift chain.
`default_nettype none

module mtw_cell (
	input  wire                 clk,
	input  wire                 shift_en,
	input  mtw_pkg::word_t      d,
	output mtw_pkg::word_t      q
);

	mtw_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

`default_nettype wire

[src/mtw_seeder.sv]
// Seeding unit: runs the initialisation recurrence, one word per cycle.
`default_nettype none

module mtw_seeder (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   seed_we,
	input  mtw_pkg::word_t        seed_value,
	output mtw_pkg::fill_ctrl_t   ctrl,
	output mtw_pkg::word_t        fill_word
);

	mtw_pkg::word_t     gen_q;
	mtw_pkg::fill_cnt_t cnt_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q  <= mtw_pkg::SEED_RESET;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (seed_we) begin
			gen_q  <= seed_value;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			gen_q <= mtw_pkg::init_next(gen_q, cnt_q + mtw_pkg::fill_cnt_t'(1));
			if (cnt_q == mtw_pkg::FILL_LAST) begin
				cnt_q  <= '0;
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + mtw_pkg::fill_cnt_t'(1);
			end
		end
	end

	assign ctrl.busy = busy_q;
	assign ctrl.last = busy_q && (cnt_q == mtw_pkg::FILL_LAST);
	assign fill_word = gen_q;

endmodule

`default_nettype wire

[src/mtw_twist.sv]
// Twist of the head word and tempering of the result.
`default_nettype none

module mtw_twist (
	input  mtw_pkg::word_t head,
	input  mtw_pkg::word_t next,
	input  mtw_pkg::word_t tap,
	output mtw_pkg::word_t twisted,
	output mtw_pkg::word_t tempered
);

	always_comb begin
		twisted  = mtw_pkg::twist_word(head, next, tap);
		tempered = mtw_pkg::temper(twisted);
	end

endmodule

`default_nettype wire
